// File: src/nell_pkg.sv
// Package for the nearest-entry lattice lookup block.
// Holds table geometry, mode/status codes, state codes and the control and status structs.
// No dependencies.
package nell_pkg;

  localparam int Entries = 256;
  localparam int IdxW    = $clog2(Entries);
  localparam int CntW    = IdxW + 1;
  localparam int EntryW  = 128;

  localparam logic [1:0] ModeClear = 2'd0;
  localparam logic [1:0] ModeLoad  = 2'd1;

  localparam logic [2:0] StatTable = 3'd0;
  localparam logic [2:0] StatEmpty = 3'd1;
  localparam logic [2:0] StatStore = 3'd2;
  localparam logic [2:0] StatFull  = 3'd3;
  localparam logic [2:0] StatClear = 3'd4;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_SQRT  = 8'b00000010,
    ST_PASS1 = 8'b00000100,
    ST_PASS2 = 8'b00001000,
    ST_PASS3 = 8'b00010000,
    ST_FETCH = 8'b00100000,
    ST_WAIT  = 8'b01000000,
    ST_DONE  = 8'b10000000
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       latch;     // capture query word
    logic       write;     // store a load word
    logic       clear;     // zero entry count
    logic       sqrt_init;
    logic       sqrt_step;
    logic       scan_init; // restart scan counter and have flag
    logic [1:0] pass;      // 1,2,3: active pass
    logic       scan_en;
    logic       fetch;     // read the chosen entry
    logic       emit;
    logic [2:0] status;
  } ctl_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic scan_last;   // last read issued
    logic drain;       // pipeline has flushed
    logic sqrt_last;
  } sts_t;

endpackage

// File: src/nell_ctrl.sv
// Controller state machine of the lookup block.
// Depends on nell_pkg (state_t, ctl_t, sts_t, codes).
module nell_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      mode,
  input  nell_pkg::sts_t  sts,
  output logic            busy,
  output nell_pkg::ctl_t  ctl
);

  nell_pkg::state_t state, state_next;
  logic [2:0] stat, stat_next;
  logic       go;

  assign go   = start && !busy;
  assign busy = (state != nell_pkg::ST_IDLE);

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nell_pkg::ST_IDLE;
      stat  <= nell_pkg::StatTable;
    end else begin
      state <= state_next;
      stat  <= stat_next;
    end
  end

  always_comb begin
    state_next    = state;
    stat_next     = stat;
    ctl           = '0;
    ctl.status    = stat;
    case (state)
      nell_pkg::ST_IDLE: begin
        if (go) begin
          ctl.latch = 1'b1;
          if (mode == nell_pkg::ModeClear) begin
            ctl.clear  = 1'b1;
            stat_next  = nell_pkg::StatClear;
            state_next = nell_pkg::ST_DONE;
          end else if (mode == nell_pkg::ModeLoad) begin
            ctl.write  = !sts.full;
            stat_next  = sts.full ? nell_pkg::StatFull : nell_pkg::StatStore;
            state_next = nell_pkg::ST_DONE;
          end else if (sts.empty) begin
            ctl.sqrt_init = 1'b1;
            stat_next     = nell_pkg::StatEmpty;
            state_next    = nell_pkg::ST_SQRT;
          end else begin
            ctl.scan_init = 1'b1;
            stat_next     = nell_pkg::StatTable;
            state_next    = nell_pkg::ST_PASS1;
          end
        end
      end
      nell_pkg::ST_SQRT: begin
        ctl.sqrt_step = 1'b1;
        if (sts.sqrt_last) state_next = nell_pkg::ST_DONE;
      end
      nell_pkg::ST_PASS1: begin
        ctl.pass    = 2'd1;
        ctl.scan_en = 1'b1;
        if (sts.drain) begin
          ctl.scan_init = 1'b1;
          state_next    = nell_pkg::ST_PASS2;
        end
      end
      nell_pkg::ST_PASS2: begin
        ctl.pass    = 2'd2;
        ctl.scan_en = 1'b1;
        if (sts.drain) begin
          ctl.scan_init = 1'b1;
          state_next    = nell_pkg::ST_PASS3;
        end
      end
      nell_pkg::ST_PASS3: begin
        ctl.pass    = 2'd3;
        ctl.scan_en = 1'b1;
        if (sts.drain) state_next = nell_pkg::ST_FETCH;
      end
      nell_pkg::ST_FETCH: begin
        ctl.fetch  = 1'b1;
        state_next = nell_pkg::ST_WAIT;
      end
      nell_pkg::ST_WAIT: begin
        state_next = nell_pkg::ST_DONE;
      end
      nell_pkg::ST_DONE: begin
        ctl.emit   = 1'b1;
        state_next = nell_pkg::ST_IDLE;
      end
      default: state_next = nell_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: src/nell_dp.sv
// Datapath of the lookup block: entry memory, three scan passes, square root.
// Depends on nell_pkg (geometry, ctl_t, sts_t, status codes).
module nell_dp (
  input  logic                clk,
  input  logic                rst,
  input  nell_pkg::ctl_t      ctl,
  output nell_pkg::sts_t      sts,
  input  logic signed [15:0]  speed,
  input  logic signed [15:0]  curvature,
  input  logic signed [15:0]  pos_x,
  input  logic signed [15:0]  pos_y,
  input  logic signed [15:0]  heading,
  input  logic signed [15:0]  entry_mid_curvature,
  input  logic signed [15:0]  entry_final_curvature,
  input  logic signed [15:0]  entry_length,
  output logic                done,
  output logic [2:0]          status,
  output logic signed [15:0]  mid_curvature,
  output logic signed [15:0]  final_curvature,
  output logic signed [16:0]  path_length
);

  localparam int IdxW = nell_pkg::IdxW;
  localparam int CntW = nell_pkg::CntW;

  logic [nell_pkg::EntryW-1:0] mem [nell_pkg::Entries];
  logic [nell_pkg::EntryW-1:0] rd;
  logic [CntW-1:0] count;
  logic [CntW-1:0] scan;
  logic            rd_v, cmp_v;
  logic [IdxW-1:0] rd_i, cmp_i;

  // query word
  logic signed [15:0] q_v, q_k, q_x, q_y, q_h;

  // best-so-far
  logic               have;
  logic signed [15:0] bv, bk;
  logic [16:0]        bd;
  logic [33:0]        bc;
  logic [IdxW-1:0]    best;

  // Hold query word
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      q_v <= speed;
      q_k <= curvature;
      q_x <= pos_x;
      q_y <= pos_y;
      q_h <= heading;
    end
  end

  // Track entry count
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) count <= '0;
    else if (ctl.write)   count <= count + 1'b1;
  end

  assign sts.empty = (count == '0);
  assign sts.full  = (count == CntW'(nell_pkg::Entries));

  // Entry memory: one write port, one registered read port held between reads
  logic [IdxW-1:0] raddr;
  assign raddr = ctl.fetch ? best : scan[IdxW-1:0];
  always_ff @(posedge clk) begin
    if (ctl.write)
      mem[count[IdxW-1:0]] <= {speed, curvature, pos_x, pos_y, heading,
                               entry_mid_curvature, entry_final_curvature,
                               entry_length};
    if (ctl.scan_en || ctl.fetch)
      rd <= mem[raddr];
  end

  // Advance scan counter and read pipeline
  logic issue;
  assign issue = ctl.scan_en && (scan < count);
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      cmp_v <= 1'b0;
    end else begin
      rd_v  <= issue && !ctl.scan_init;
      cmp_v <= rd_v && !ctl.scan_init;
    end
    rd_i  <= scan[IdxW-1:0];
    cmp_i <= rd_i;
    if (ctl.scan_init) scan <= '0;
    else if (issue)    scan <= scan + 1'b1;
  end

  assign sts.scan_last = (scan >= count);

  // Entry fields
  logic signed [15:0] e_v, e_k, e_x, e_y, e_h;
  assign e_v = rd[127:112];
  assign e_k = rd[111:96];
  assign e_x = rd[95:80];
  assign e_y = rd[79:64];
  assign e_h = rd[63:48];

  // Stage 1: differences and gates, registered
  logic [16:0] d_key;
  logic signed [15:0] c_key;
  logic               c_match;
  logic [16:0]        dx, dy, dh;

  function automatic logic [16:0] adiff(input logic signed [15:0] a,
                                        input logic signed [15:0] b);
    logic signed [16:0] d;
    d = 17'(a) - 17'(b);
    adiff = d[16] ? 17'(-d) : d;
  endfunction

  always_ff @(posedge clk) begin
    c_match <= (ctl.pass == 2'd1) ||
               (ctl.pass == 2'd2 && e_v == bv) ||
               (ctl.pass == 2'd3 && e_v == bv && e_k == bk);
    c_key   <= (ctl.pass == 2'd1) ? e_v : e_k;
    d_key   <= (ctl.pass == 2'd1) ? adiff(e_v, q_v) : adiff(e_k, q_k);
    dx      <= adiff(q_x, e_x);
    dy      <= adiff(q_y, e_y);
    dh      <= adiff(q_h, e_h);
  end

  // Stage 2: squares, then compare on the following edge
  logic [33:0] sq_sum;
  logic [16:0] p_key;
  logic signed [15:0] p_kv;
  logic        p_match, p_v;
  logic [IdxW-1:0] p_i;
  always_ff @(posedge clk) begin
    sq_sum  <= 34'(dx * dx) + 34'(dy * dy) + 34'(dh * dh);
    p_key   <= d_key;
    p_kv    <= c_key;
    p_match <= c_match;
    p_i     <= cmp_i;
    p_v     <= rst ? 1'b0 : (cmp_v && !ctl.scan_init);
  end

  // Flag drain once the last compare has retired
  assign sts.drain = sts.scan_last && !rd_v && !cmp_v && !p_v && ctl.scan_en;

  // Update best entry
  logic better;
  always_comb begin
    better = 1'b0;
    if (ctl.pass == 2'd3)
      better = !have || (sq_sum < bc);
    else
      better = !have || (p_key < bd) || (p_key == bd && p_kv < (ctl.pass == 2'd1 ? bv : bk));
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.scan_init) begin
      have <= 1'b0;
    end else if (p_v && p_match && better) begin
      have <= 1'b1;
      bd   <= p_key;
      bc   <= sq_sum;
      best <= p_i;
      if (ctl.pass == 2'd1) bv <= p_kv;
      if (ctl.pass == 2'd2) bk <= p_kv;
    end
  end

  // Square root, one result bit per step over a 34-bit radicand
  logic [33:0] s_in, s_n;
  logic [35:0] s_r;
  logic [4:0]  s_cnt;
  logic [35:0] s_bit;
  always_ff @(posedge clk) begin
    if (ctl.sqrt_init) begin
      s_in  <= 34'(adiff(pos_x, 16'sd0) * adiff(pos_x, 16'sd0)) +
               34'(adiff(pos_y, 16'sd0) * adiff(pos_y, 16'sd0));
      s_n   <= 34'(adiff(pos_x, 16'sd0) * adiff(pos_x, 16'sd0)) +
               34'(adiff(pos_y, 16'sd0) * adiff(pos_y, 16'sd0));
      s_r   <= '0;
      s_bit <= 36'h400000000;
      s_cnt <= '0;
    end else if (ctl.sqrt_step) begin
      s_cnt <= s_cnt + 1'b1;
      s_bit <= s_bit >> 2;
      if (36'(s_n) >= s_r + s_bit) begin
        s_n <= 34'(36'(s_n) - s_r - s_bit);
        s_r <= (s_r >> 1) + s_bit;
      end else begin
        s_r <= s_r >> 1;
      end
    end
  end
  assign sts.sqrt_last = (s_cnt == 5'd17);

  // Final rounding of the root
  logic [17:0] r_fl;
  logic [17:0] root;
  assign r_fl = s_r[17:0];
  assign root = (36'(s_in) - 36'(r_fl * r_fl) > 36'(r_fl)) ? r_fl + 1'b1 : r_fl;

  // Drive result word
  always_comb begin
    done            = ctl.emit;
    status          = ctl.status;
    mid_curvature   = '0;
    final_curvature = '0;
    path_length     = '0;
    if (ctl.status == nell_pkg::StatTable) begin
      mid_curvature   = rd[47:32];
      final_curvature = rd[31:16];
      path_length     = 17'(signed'(rd[15:0]));
    end else if (ctl.status == nell_pkg::StatEmpty) begin
      path_length = 17'(root);
    end
  end

endmodule

// File: src/nearest_entry_lattice_lookup.sv
// Top level of the nearest-entry lattice lookup block.
// Depends on nell_pkg, nell_ctrl and nell_dp.
//
// Usage: raise start with a command word (mode and fields) while busy is
// low; the word is taken at that edge. mode 0 clears the table, mode 1
// loads one entry, mode 2 (or 3) queries the nearest entry.
// Each command gives exactly one result word, shown for one cycle with
// done high: status, mid_curvature, final_curvature, path_length.
// Clear and load go from the idle state straight to the done state. A query
// on an empty table runs an 18-step square root. A query on a loaded table
// makes three scans over the N stored entries through the single read port
// of the entry memory, then reads the chosen entry. busy stays high until
// the result cycle ends.
// Reset (rst, synchronous) empties the table and returns to idle; memory
// contents need no clearing. The receiver cannot stall: done is a strobe.
module nearest_entry_lattice_lookup (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic signed [15:0] speed,
  input  logic signed [15:0] curvature,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] heading,
  input  logic signed [15:0] entry_mid_curvature,
  input  logic signed [15:0] entry_final_curvature,
  input  logic signed [15:0] entry_length,
  output logic               done,
  output logic [2:0]         status,
  output logic signed [15:0] mid_curvature,
  output logic signed [15:0] final_curvature,
  output logic signed [16:0] path_length
);

  nell_pkg::ctl_t ctl;
  nell_pkg::sts_t sts;

  nell_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  nell_dp u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .ctl                   (ctl),
    .sts                   (sts),
    .speed                 (speed),
    .curvature             (curvature),
    .pos_x                 (pos_x),
    .pos_y                 (pos_y),
    .heading               (heading),
    .entry_mid_curvature   (entry_mid_curvature),
    .entry_final_curvature (entry_final_curvature),
    .entry_length          (entry_length),
    .done                  (done),
    .status                (status),
    .mid_curvature         (mid_curvature),
    .final_curvature       (final_curvature),
    .path_length           (path_length)
  );

endmodule

// File: src/nell_checker.sv
// Port checker for the lookup block, bound to the top level.
// Depends on nell_pkg codes and the nearest_entry_lattice_lookup ports.
module nell_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [1:0]        mode,
  input logic              done,
  input logic [2:0]        status,
  input logic signed [15:0] mid_curvature,
  input logic signed [16:0] path_length
);

  // A result word ends the command
  assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after result");

  // A taken command makes the block busy
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("command not taken");

  // Clear answers with the cleared status
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == nell_pkg::ModeClear) |=>
      (done && status == nell_pkg::StatClear))
    else $error("clear result wrong");

  // Non-table answers carry zero curvature
  assert property (@(posedge clk) disable iff (rst)
    (done && status != nell_pkg::StatTable) |-> (mid_curvature == 16'sd0))
    else $error("stray curvature");

  // Load and clear answers carry zero length
  assert property (@(posedge clk) disable iff (rst)
    (done && status != nell_pkg::StatTable && status != nell_pkg::StatEmpty) |->
      (path_length == 17'sd0))
    else $error("stray length");

endmodule

bind nearest_entry_lattice_lookup nell_checker u_nell_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .mode           (mode),
  .done           (done),
  .status         (status),
  .mid_curvature  (mid_curvature),
  .path_length    (path_length)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for nearest_entry_lattice_lookup.
// Depends on nell_pkg; predicts every result word in-line and checks it on done.
module testbench;

  localparam logic [1:0] ModeQuery = 2'd2;
  localparam logic [1:0] ModeSpare = 2'd3;
  localparam int         Settle    = 40;

  typedef struct {
    logic [1:0]         mode;
    logic signed [15:0] spd, crv, px, py, hd, km, kf, len;
    int                 gap;
  } cmd_t;

  typedef struct {
    logic [2:0]         status;
    logic signed [15:0] mid, fin;
    logic signed [16:0] plen;
  } answer_t;

  typedef struct {
    logic signed [15:0] spd, crv, ex, ey, eh, km, kf, len;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         mode = '0;
  logic signed [15:0] speed = '0, curvature = '0, pos_x = '0, pos_y = '0, heading = '0;
  logic signed [15:0] entry_mid_curvature = '0, entry_final_curvature = '0;
  logic signed [15:0] entry_length = '0;
  logic               busy, done;
  logic [2:0]         status;
  logic signed [15:0] mid_curvature, final_curvature;
  logic signed [16:0] path_length;

  cmd_t    cmd_words[$];
  answer_t answers_due[$];
  cmd_t    cur_word;
  row_t    table_rows[nell_pkg::Entries];
  int      row_count = 0;
  int      errors = 0;

  nearest_entry_lattice_lookup dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Rounded square root: floor by bisection, then round up past the midpoint.
  function automatic longint unsigned round_root(longint unsigned s);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 1 << 20;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= s) lo = mid;
      else hi = mid - 1;
    end
    if (s - lo * lo > lo) lo++;
    return lo;
  endfunction

  function automatic longint sq(longint a, longint b);
    return (a - b) * (a - b);
  endfunction

  function automatic longint absd(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Apply one word to the table copy and return the answer it must produce.
  function automatic answer_t predict_answer(cmd_t c);
    answer_t a;
    longint  bd, d, bc, cst;
    logic signed [15:0] bv, bk;
    int      best;
    bit      have;
    a = '{nell_pkg::StatTable, 16'sd0, 16'sd0, 17'sd0};
    if (c.mode == nell_pkg::ModeClear) begin
      row_count = 0;
      a.status = nell_pkg::StatClear;
    end else if (c.mode == nell_pkg::ModeLoad) begin
      if (row_count < nell_pkg::Entries) begin
        table_rows[row_count] = '{c.spd, c.crv, c.px, c.py, c.hd, c.km, c.kf, c.len};
        row_count++;
        a.status = nell_pkg::StatStore;
      end else begin
        a.status = nell_pkg::StatFull;
      end
    end else if (row_count == 0) begin
      a.status = nell_pkg::StatEmpty;
      a.plen = 17'(round_root(longint'(sq(c.px, 0) + sq(c.py, 0))));
    end else begin
      have = 0; bd = 0; bv = 0; bk = 0; bc = 0; best = 0;
      for (int i = 0; i < row_count; i++) begin
        d = absd(table_rows[i].spd, c.spd);
        if (!have || d < bd || (d == bd && table_rows[i].spd < bv)) begin
          bd = d; bv = table_rows[i].spd; have = 1;
        end
      end
      have = 0;
      for (int i = 0; i < row_count; i++) begin
        if (table_rows[i].spd != bv) continue;
        d = absd(table_rows[i].crv, c.crv);
        if (!have || d < bd || (d == bd && table_rows[i].crv < bk)) begin
          bd = d; bk = table_rows[i].crv; have = 1;
        end
      end
      have = 0;
      for (int i = 0; i < row_count; i++) begin
        if (table_rows[i].spd != bv || table_rows[i].crv != bk) continue;
        cst = sq(c.px, table_rows[i].ex) + sq(c.py, table_rows[i].ey)
            + sq(c.hd, table_rows[i].eh);
        if (!have || cst < bc) begin
          bc = cst; best = i; have = 1;
        end
      end
      a.mid  = table_rows[best].km;
      a.fin  = table_rows[best].kf;
      a.plen = 17'(table_rows[best].len);
    end
    return a;
  endfunction

  function automatic void put_word(logic [1:0] m, logic signed [15:0] s, k, x, y, h,
                                   logic signed [15:0] km, kf, ln, int gap);
    cmd_t c;
    c = '{m, s, k, x, y, h, km, kf, ln, gap};
    cmd_words.insert(cmd_words.size(), c);
  endfunction

  function automatic logic signed [15:0] any16();
    return 16'($urandom);
  endfunction

  // Keys come mostly from a short list so that ties and shared keys occur.
  function automatic logic signed [15:0] pick_key();
    logic signed [15:0] keys[6] = '{-16'sd512, -16'sd256, 16'sd0, 16'sd256, 16'sd512,
                                    16'sd768};
    if ($urandom_range(3) != 0) return keys[$urandom_range(5)];
    return any16();
  endfunction

  function automatic logic signed [15:0] pick_pos();
    if ($urandom_range(1) != 0) return 16'($signed($urandom_range(8)) - 4) * 16'sd64;
    return any16();
  endfunction

  function automatic void random_load(int gap);
    put_word(nell_pkg::ModeLoad, pick_key(), pick_key(), pick_pos(), pick_pos(),
             pick_pos(), any16(), any16(), any16(), gap);
  endfunction

  function automatic void random_query(logic [1:0] m, int gap);
    put_word(m, pick_key(), pick_key(), pick_pos(), pick_pos(), pick_pos(),
             any16(), any16(), any16(), gap);
  endfunction

  // A random mix of loads and queries with occasional clears; a little noise on top.
  function automatic void random_phase(int gap, int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 8) put_word(nell_pkg::ModeClear, any16(), any16(), any16(), any16(),
                          any16(), any16(), any16(), any16(), gap);
      else if (r < 50) random_load(gap);
      else if (r < 95) random_query(ModeQuery, gap);
      else random_query(ModeSpare, gap);
    end
  endfunction

  function automatic void fill_phase(int gap);
    put_word(nell_pkg::ModeClear, 0, 0, 0, 0, 0, 0, 0, 0, gap);
    for (int i = 0; i < nell_pkg::Entries + 3; i++) random_load(gap);
    for (int i = 0; i < 12; i++) random_query(ModeQuery, gap);
  endfunction

  // Stimulus list: directed corner words first, then the random phases.
  initial begin
    put_word(ModeQuery, 0, 0, 16'sh8000, 16'sh8000, 0, 0, 0, 0, 0);
    put_word(ModeQuery, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    put_word(ModeSpare, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8001, 16'sh7fff,
             16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    put_word(nell_pkg::ModeLoad, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
             16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    put_word(nell_pkg::ModeLoad, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
             16'sh8000, 16'sh8000, 16'sh8000, 0);
    put_word(ModeQuery, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    put_word(ModeQuery, 16'sh7fff, 0, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 0);
    put_word(nell_pkg::ModeClear, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // equally near speeds, curvatures and poses
    put_word(nell_pkg::ModeLoad, 256, 100, 0, 0, 0, 11, 12, 13, 0);
    put_word(nell_pkg::ModeLoad, 768, 100, 0, 0, 0, 21, 22, 23, 0);
    put_word(ModeQuery, 512, 100, 0, 0, 0, 0, 0, 0, 0);
    put_word(nell_pkg::ModeLoad, 256, 300, 0, 0, 0, 31, 32, 33, 0);
    put_word(ModeQuery, 256, 200, 0, 0, 0, 0, 0, 0, 0);
    put_word(nell_pkg::ModeLoad, 256, 100, 5, 5, 5, 41, 42, 43, 0);
    put_word(nell_pkg::ModeLoad, 256, 100, 5, 5, 5, 51, 52, 53, 0);
    put_word(ModeQuery, 256, 100, 5, 5, 5, 0, 0, 0, 0);
    put_word(ModeQuery, 256, 100, 3, 3, 3, 0, 0, 0, 0);
    // far goal still picks the nearest entry
    put_word(ModeQuery, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 0, 0, 0, 0);
    put_word(ModeSpare, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 0, 0, 0, 0);
    put_word(nell_pkg::ModeClear, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    put_word(ModeQuery, 0, 0, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0, 0);
    random_phase(0, 70);
    random_phase(88, 70);
    fill_phase(0);
    random_phase(15, 70);
    random_phase(0, 70);
  end

  // Driver: hold the word while busy, then present the next one or idle.
  always @(posedge clk) begin : drive_words
    cmd_t nxt;
    bit   fire;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        answers_due.insert(answers_due.size(), predict_answer(cur_word));
      if (!(start && busy)) begin
        fire = 1'b0;
        if (cmd_words.size() > 0 && $urandom_range(99) >= cmd_words[0].gap) begin
          nxt = cmd_words.pop_front();
          fire = 1'b1;
          cur_word = nxt;
          mode <= nxt.mode;
          speed <= nxt.spd;
          curvature <= nxt.crv;
          pos_x <= nxt.px;
          pos_y <= nxt.py;
          heading <= nxt.hd;
          entry_mid_curvature <= nxt.km;
          entry_final_curvature <= nxt.kf;
          entry_length <= nxt.len;
        end
        start <= fire;
      end
    end
  end

  // Monitor: check each result word against the oldest prediction.
  always @(posedge clk) begin : check_words
    answer_t e;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result word status=%0d", $time, status);
        errors++;
      end else begin
        e = answers_due.pop_front();
        if (status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status);
          errors++;
        end
        if (mid_curvature !== e.mid) begin
          $display("%0t: mid_curvature expected %0d actual %0d", $time, e.mid,
                   mid_curvature);
          errors++;
        end
        if (final_curvature !== e.fin) begin
          $display("%0t: final_curvature expected %0d actual %0d", $time, e.fin,
                   final_curvature);
          errors++;
        end
        if (path_length !== e.plen) begin
          $display("%0t: path_length expected %0d actual %0d", $time, e.plen,
                   path_length);
          errors++;
        end
      end
    end
  end

  // Reset, then wait for the stimulus and the results to drain.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (cmd_words.size() > 0 || start || answers_due.size() > 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
